/* rtl/edid_pkg.sv */
// Shared types, constants and helpers for the EDID base block parser.
package edid_pkg;

	localparam int BLOCK_BYTES = 128;
	localparam int TEXT_CHARS  = 12;
	localparam int NUM_KINDS   = 3;
	localparam int STR_DEPTH   = NUM_KINDS * TEXT_CHARS;
	localparam int STR_ADDR_W  = $clog2(STR_DEPTH);

	localparam logic [7:0] OFF_HDR0     = 8'h00;
	localparam logic [7:0] OFF_HDR1     = 8'h01;
	localparam logic [7:0] HDR0_VAL     = 8'h00;
	localparam logic [7:0] HDR1_VAL     = 8'hff;
	localparam logic [7:0] OFF_MAKER0   = 8'h08;
	localparam logic [7:0] OFF_MAKER1   = 8'h09;
	localparam logic [7:0] OFF_SERIAL   = 8'h0c;
	localparam logic [7:0] OFF_SERIAL_E = 8'h0f;
	localparam logic [7:0] DESC_FIRST   = 8'h36;
	localparam logic [7:0] DESC_END     = 8'h7e;
	localparam logic [7:0] OFF_MAX      = 8'hff;

	localparam logic [4:0] DESC_POS_LAST  = 5'd17;
	localparam logic [4:0] DESC_POS_FLAG0 = 5'd0;
	localparam logic [4:0] DESC_POS_FLAG2 = 5'd2;
	localparam logic [4:0] DESC_POS_TAG   = 5'd3;
	localparam logic [4:0] TEXT_POS_FIRST = 5'd5;
	localparam logic [4:0] TEXT_POS_LAST  = 5'd16;

	localparam logic [7:0] TAG_NAME   = 8'hfc;
	localparam logic [7:0] TAG_SERIAL = 8'hff;
	localparam logic [7:0] TAG_ALNUM  = 8'hfe;

	localparam logic [1:0] KIND_NAME   = 2'd0;
	localparam logic [1:0] KIND_SERIAL = 2'd1;
	localparam logic [1:0] KIND_ALNUM  = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	localparam logic [1:0] REC_SUMMARY = 2'd0;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_DASH  = 8'h2d;
	localparam logic [7:0] PRINT_LOW  = 8'h20;
	localparam logic [7:0] PRINT_HIGH = 8'h7e;
	localparam logic [3:0] MAX_REPLACED = 4'd4;
	localparam logic [6:0] LETTER_BASE  = 7'h40;

	typedef struct packed {
		logic [7:0] edid_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic        block_ok;
		logic [6:0]  maker_letter_one;
		logic [6:0]  maker_letter_two;
		logic [6:0]  maker_letter_three;
		logic [31:0] numeric_serial;
		logic        numeric_serial_used;
		logic [3:0]  char_index;
		logic [7:0]  char_value;
		logic [3:0]  text_length;
		logic        last_record;
	} result_t;

	typedef struct packed {
		logic take;
		logic sum_out;
		logic issue;
		logic clear;
	} dp_cmd_t;

	typedef struct packed {
		logic ok;
		logic has_chars;
		logic issue_last;
	} dp_sts_t;

	function automatic logic [1:0] kind_of_tag(input logic [7:0] tag);
		logic [1:0] k;
		k = KIND_NONE;
		if (tag == TAG_NAME)
			k = KIND_NAME;
		else if (tag == TAG_SERIAL)
			k = KIND_SERIAL;
		else if (tag == TAG_ALNUM)
			k = KIND_ALNUM;
		return k;
	endfunction

endpackage

/* rtl/edid_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module edid_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 36
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* rtl/edid_dp.sv */
// Datapath: byte parsing, string cleaning, kept-string RAM and record output.
module edid_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  edid_pkg::in_item_t in_item,
	input  edid_pkg::dp_cmd_t  cmd,
	output edid_pkg::dp_sts_t  sts,
	output logic               strobe,
	output edid_pkg::result_t  result
);
	import edid_pkg::*;

	function automatic logic [1:0] first_from(input logic [2:0] from,
			input logic [3:0][3:0] lens);
		logic [1:0] r;
		r = KIND_NONE;
		for (int j = NUM_KINDS - 1; j >= 0; j--) begin
			if (3'(j) >= from && lens[j] != 4'd0)
				r = 2'(j);
		end
		return r;
	endfunction

	logic [7:0]  off_q;
	logic        hdr_good_q;
	logic [7:0]  maker0_q;
	logic [7:0]  maker1_q;
	logic [31:0] serial_q;
	logic [1:0]  flags_q;
	logic [7:0]  tag_q;
	logic [4:0]  pos_q;
	logic        term_q;
	logic [3:0]  tlen_q;
	logic [3:0]  rep_q;
	logic [3:0]  len_q [NUM_KINDS];
	logic        serial_seen_q;
	logic [1:0]  rd_k_q;
	logic [3:0]  rd_i_q;

	logic        valid_s1;
	logic [1:0]  k_s1;
	logic [3:0]  i_s1;
	logic [3:0]  len_s1;
	logic        last_s1;

	logic [7:0]  b;
	logic        in_block;
	logic        in_desc;
	logic        in_text;
	logic [3:0]  text_idx;
	logic [1:0]  kind;
	logic        sel;
	logic        is_term;
	logic        nonprint;
	logic        keep_char;
	logic [7:0]  clean;
	logic [3:0]  rep_next;
	logic [3:0]  fin_len;
	logic [3:0]  fin_kept;
	logic        wr_en;
	logic [STR_ADDR_W-1:0] wr_addr;
	logic [STR_ADDR_W-1:0] rd_addr;
	logic [7:0]  rd_data;

	logic [3:0][3:0] lens;
	logic [1:0]  first_k;
	logic [1:0]  cur_k;
	logic [3:0]  cur_i;
	logic [3:0]  cur_len;
	logic        adv_more;
	logic [1:0]  nxt_k;
	logic [3:0]  nxt_i;

	always_comb begin
		b         = in_item.edid_byte;
		in_block  = !off_q[7];
		in_desc   = in_block && off_q >= DESC_FIRST && off_q < DESC_END;
		in_text   = pos_q >= TEXT_POS_FIRST && pos_q <= TEXT_POS_LAST;
		text_idx  = 4'(pos_q - TEXT_POS_FIRST);
		kind      = kind_of_tag(tag_q);
		sel       = flags_q == 2'b11 && kind != KIND_NONE;
		is_term   = b == CHAR_NUL || b == CHAR_LF || b == CHAR_CR;
		nonprint  = b < PRINT_LOW || b > PRINT_HIGH;
		keep_char = !term_q && !is_term;
		clean     = nonprint ? CHAR_DASH : b;
		rep_next  = rep_q + 4'(keep_char && nonprint);
		if (term_q)
			fin_len = tlen_q;
		else if (is_term)
			fin_len = text_idx;
		else
			fin_len = 4'(TEXT_CHARS);
		fin_kept  = (rep_next > MAX_REPLACED) ? 4'd0 : fin_len;
		wr_en     = cmd.take && in_desc && in_text && sel && keep_char;
		wr_addr   = STR_ADDR_W'(kind) * STR_ADDR_W'(TEXT_CHARS) + STR_ADDR_W'(text_idx);
	end

	// Walk over kept characters, skipping empty strings.
	always_comb begin
		lens     = {4'd0, len_q[2], len_q[1], len_q[0]};
		first_k  = first_from(3'd0, lens);
		cur_k    = cmd.sum_out ? first_k : rd_k_q;
		cur_i    = cmd.sum_out ? 4'd0 : rd_i_q;
		cur_len  = lens[cur_k];
		adv_more = ({1'b0, cur_i} + 5'd1) < {1'b0, cur_len};
		nxt_k    = adv_more ? cur_k : first_from({1'b0, cur_k} + 3'd1, lens);
		nxt_i    = adv_more ? cur_i + 4'd1 : 4'd0;
		rd_addr  = STR_ADDR_W'(cur_k) * STR_ADDR_W'(TEXT_CHARS) + STR_ADDR_W'(cur_i);
		sts.ok         = off_q[7] && hdr_good_q;
		sts.has_chars  = first_k != KIND_NONE;
		sts.issue_last = nxt_k == KIND_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q         <= '0;
			hdr_good_q    <= 1'b1;
			maker0_q      <= '0;
			maker1_q      <= '0;
			serial_q      <= '0;
			flags_q       <= '0;
			tag_q         <= '0;
			pos_q         <= '0;
			term_q        <= 1'b0;
			tlen_q        <= '0;
			rep_q         <= '0;
			serial_seen_q <= 1'b0;
			for (int j = 0; j < NUM_KINDS; j++)
				len_q[j] <= '0;
		end else if (cmd.clear) begin
			off_q         <= '0;
			hdr_good_q    <= 1'b1;
			maker0_q      <= '0;
			maker1_q      <= '0;
			serial_q      <= '0;
			flags_q       <= '0;
			tag_q         <= '0;
			pos_q         <= '0;
			term_q        <= 1'b0;
			tlen_q        <= '0;
			rep_q         <= '0;
			serial_seen_q <= 1'b0;
			for (int j = 0; j < NUM_KINDS; j++)
				len_q[j] <= '0;
		end else if (cmd.take) begin
			if (off_q != OFF_MAX)
				off_q <= off_q + 8'd1;
			if (in_block) begin
				if (off_q == OFF_HDR0 && b != HDR0_VAL)
					hdr_good_q <= 1'b0;
				if (off_q == OFF_HDR1 && b != HDR1_VAL)
					hdr_good_q <= 1'b0;
				if (off_q == OFF_MAKER0)
					maker0_q <= b;
				if (off_q == OFF_MAKER1)
					maker1_q <= b;
				if (off_q >= OFF_SERIAL && off_q <= OFF_SERIAL_E)
					serial_q[8*off_q[1:0] +: 8] <= b;
				if (in_desc) begin
					pos_q <= (pos_q == DESC_POS_LAST) ? 5'd0 : pos_q + 5'd1;
					if (pos_q == DESC_POS_FLAG0) begin
						flags_q <= {1'b0, b == 8'd0};
						term_q  <= 1'b0;
						rep_q   <= '0;
					end
					if (pos_q == DESC_POS_FLAG2)
						flags_q[1] <= b == 8'd0;
					if (pos_q == DESC_POS_TAG)
						tag_q <= b;
					if (in_text) begin
						rep_q <= rep_next;
						if (!term_q && is_term) begin
							term_q <= 1'b1;
							tlen_q <= text_idx;
						end
						if (pos_q == TEXT_POS_LAST && sel) begin
							len_q[kind] <= fin_kept;
							if (kind == KIND_SERIAL)
								serial_seen_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= cmd.issue;
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			k_s1    <= cur_k;
			i_s1    <= cur_i;
			len_s1  <= cur_len;
			last_s1 <= sts.issue_last;
			rd_k_q  <= nxt_k;
			rd_i_q  <= nxt_i;
		end
	end

	edid_ram #(
		.WIDTH(8),
		.DEPTH(STR_DEPTH)
	) u_str_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(clean),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		result = '0;
		strobe = cmd.sum_out || valid_s1;
		if (cmd.sum_out) begin
			result.record_kind = REC_SUMMARY;
			result.block_ok    = sts.ok;
			if (sts.ok) begin
				result.maker_letter_one    = LETTER_BASE + {2'b00, maker0_q[6:2]};
				result.maker_letter_two    = LETTER_BASE + {2'b00, maker0_q[1:0], maker1_q[7:5]};
				result.maker_letter_three  = LETTER_BASE + {2'b00, maker1_q[4:0]};
				result.numeric_serial      = serial_q;
				result.numeric_serial_used = serial_q != 32'd0 && !serial_seen_q;
			end
			result.last_record = !(sts.ok && sts.has_chars);
		end else if (valid_s1) begin
			result.record_kind = k_s1 + 2'd1;
			result.block_ok    = 1'b1;
			result.char_index  = i_s1;
			result.char_value  = rd_data;
			result.text_length = len_s1;
			result.last_record = last_s1;
		end
	end

	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.sum_out && valid_s1))
		else $error("summary and character record in the same cycle");

	a_take_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> !valid_s1)
		else $error("item taken while a character record is in flight");

	a_read_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (cur_k != KIND_NONE && cur_i < cur_len))
		else $error("string read outside kept characters");

endmodule

/* rtl/edid_ctrl.sv */
// Controller: byte intake and record emission sequencing.
module edid_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              last_byte,
	input  edid_pkg::dp_sts_t sts,
	output edid_pkg::dp_cmd_t cmd,
	output logic              busy
);
	import edid_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_RUN,
		ST_FLUSH
	} state_t;

	state_t state_q;

	always_comb begin
		cmd      = '0;
		busy     = state_q != ST_IDLE;
		cmd.take = start && !busy;
		case (state_q)
			ST_SUM: begin
				cmd.sum_out = 1'b1;
				if (sts.ok && sts.has_chars)
					cmd.issue = 1'b1;
				else
					cmd.clear = 1'b1;
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
			end
			ST_FLUSH: begin
				cmd.clear = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.take && last_byte)
						state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (cmd.issue)
						state_q <= sts.issue_last ? ST_FLUSH : ST_RUN;
					else
						state_q <= ST_IDLE;
				end
				ST_RUN: begin
					if (sts.issue_last)
						state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_clear_on_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(cmd.clear))
		else $error("returned idle without clearing block state");

endmodule

/* rtl/edid_base_block_parser_unit.sv */
// Top level of the EDID base block parser.
//
//  channel   dir  handshake               payload
//  input     in   start & !busy           in_item (edid_byte, last_byte)
//  result    out  strobe, one cycle       result (summary / character record)
//
// One byte per cycle is taken while busy is low. The item carrying last_byte
// raises busy while its records go out: the summary record, then one
// character record per cycle for each of the N kept characters (0..36),
// paced by the single read port of the kept-string RAM. A bad or short
// block gives the summary alone. The receiver cannot stall; reset clears
// all parse state and the block clears itself after each run.
module edid_base_block_parser_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  edid_pkg::in_item_t in_item,
	output logic               strobe,
	output edid_pkg::result_t  result
);
	import edid_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	edid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.last_byte(in_item.last_byte),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	edid_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.in_item(in_item),
		.cmd    (cmd),
		.sts    (sts),
		.strobe (strobe),
		.result (result)
	);

endmodule

/* bench/edid_base_block_parser_unit_test.sv */
// Self-checking testbench for the EDID base block parser: byte stream in, summary and string records out.
module edid_base_block_parser_unit_test;
	import edid_pkg::*;

	localparam logic [1:0] REC_NAME_CHAR   = 2'd1;
	localparam logic [1:0] REC_SERIAL_CHAR = 2'd2;
	localparam logic [1:0] REC_ALNUM_CHAR  = 2'd3;
	localparam int         MAX_BLOCK_LEN   = 300;
	localparam int         CYCLE_LIMIT     = 200000;
	localparam int         DRAIN_CYCLES    = 60;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	in_item_t in_item;
	logic     strobe;
	result_t  result;

	edid_base_block_parser_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_item(in_item),
		.strobe(strobe),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser state mirror
	logic [7:0] byte_count;
	logic       header_valid;
	logic [7:0] maker_code [0:1];
	logic [31:0] serial_acc;
	logic [1:0] desc_flags;
	logic [7:0] desc_tag;
	logic [7:0] desc_text [0:TEXT_CHARS-1];
	logic [7:0] kept_text [0:NUM_KINDS-1][0:TEXT_CHARS-1];
	logic [3:0] kept_len [0:NUM_KINDS-1];
	logic       serial_text_found;

	result_t expected_records [$];
	int      records_predicted = 0;
	int      mismatches = 0;
	int      items_sent = 0;
	int      burst_left = 0;

	logic [7:0] block_bytes [0:MAX_BLOCK_LEN-1];
	int         block_len;

	task automatic clear_parse_state();
		byte_count = '0;
		header_valid = 1'b1;
		maker_code[0] = '0;
		maker_code[1] = '0;
		serial_acc = '0;
		desc_flags = '0;
		desc_tag = '0;
		serial_text_found = 1'b0;
		for (int i = 0; i < TEXT_CHARS; i++)
			desc_text[i] = '0;
		for (int k = 0; k < NUM_KINDS; k++) begin
			kept_len[k] = '0;
			for (int i = 0; i < TEXT_CHARS; i++)
				kept_text[k][i] = '0;
		end
	endtask

	task automatic keep_text(input int kind);
		int len;
		int replaced;
		logic cut;
		logic [7:0] c;
		len = TEXT_CHARS;
		cut = 1'b0;
		replaced = 0;
		for (int i = 0; i < TEXT_CHARS; i++)
			if (!cut && (desc_text[i] == CHAR_NUL || desc_text[i] == CHAR_LF ||
					desc_text[i] == CHAR_CR)) begin
				len = i;
				cut = 1'b1;
			end
		for (int i = 0; i < len; i++) begin
			c = desc_text[i];
			if (c < PRINT_LOW || c > PRINT_HIGH) begin
				c = CHAR_DASH;
				replaced++;
			end
			kept_text[kind][i] = c;
		end
		if (replaced > MAX_REPLACED)
			len = 0;
		kept_len[kind] = 4'(len);
		if (kind == KIND_SERIAL)
			serial_text_found = 1'b1;
	endtask

	task automatic absorb_edid_byte(input logic [7:0] b);
		int off;
		int p;
		off = byte_count;
		if (byte_count != OFF_MAX)
			byte_count = byte_count + 8'd1;
		if (off >= BLOCK_BYTES)
			return;
		if (off == OFF_HDR0 && b != HDR0_VAL)
			header_valid = 1'b0;
		if (off == OFF_HDR1 && b != HDR1_VAL)
			header_valid = 1'b0;
		if (off == OFF_MAKER0)
			maker_code[0] = b;
		if (off == OFF_MAKER1)
			maker_code[1] = b;
		if (off >= OFF_SERIAL && off <= OFF_SERIAL_E)
			serial_acc = serial_acc | (32'(b) << (8 * (off - int'(OFF_SERIAL))));
		if (off >= DESC_FIRST && off < DESC_END) begin
			p = (off - int'(DESC_FIRST)) % (int'(DESC_POS_LAST) + 1);
			if (p == DESC_POS_FLAG0)
				desc_flags = {1'b0, b == 8'h00};
			else if (p == DESC_POS_FLAG2)
				desc_flags[1] = desc_flags[1] | (b == 8'h00);
			else if (p == DESC_POS_TAG)
				desc_tag = b;
			else if (p >= TEXT_POS_FIRST && p <= TEXT_POS_LAST) begin
				desc_text[p - TEXT_POS_FIRST] = b;
				if (p == TEXT_POS_LAST && desc_flags == 2'b11) begin
					case (desc_tag)
						TAG_NAME:   keep_text(KIND_NAME);
						TAG_SERIAL: keep_text(KIND_SERIAL);
						TAG_ALNUM:  keep_text(KIND_ALNUM);
						default: ;
					endcase
				end
			end
		end
	endtask

	task automatic emit_block_records();
		result_t rec;
		logic ok;
		int total;
		int n;
		ok = (byte_count >= BLOCK_BYTES) && header_valid;
		total = 0;
		if (ok)
			for (int k = 0; k < NUM_KINDS; k++)
				total += kept_len[k];
		rec = '0;
		rec.record_kind = REC_SUMMARY;
		rec.block_ok = ok;
		if (ok) begin
			rec.maker_letter_one = LETTER_BASE + 7'(maker_code[0][6:2]);
			rec.maker_letter_two = LETTER_BASE + 7'({maker_code[0][1:0], maker_code[1][7:5]});
			rec.maker_letter_three = LETTER_BASE + 7'(maker_code[1][4:0]);
			rec.numeric_serial = serial_acc;
			rec.numeric_serial_used = (serial_acc != 0) && !serial_text_found;
		end
		rec.last_record = (total == 0);
		expected_records.push_back(rec);
		records_predicted++;
		n = 1;
		if (ok)
			for (int k = 0; k < NUM_KINDS; k++)
				for (int i = 0; i < kept_len[k]; i++) begin
					rec = '0;
					case (k)
						KIND_NAME:   rec.record_kind = REC_NAME_CHAR;
						KIND_SERIAL: rec.record_kind = REC_SERIAL_CHAR;
						default:     rec.record_kind = REC_ALNUM_CHAR;
					endcase
					rec.block_ok = 1'b1;
					rec.char_index = 4'(i);
					rec.char_value = kept_text[k][i];
					rec.text_length = kept_len[k];
					rec.last_record = (n == total);
					expected_records.push_back(rec);
					records_predicted++;
					n++;
				end
		clear_parse_state();
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (mismatches < 40)
			$display("MISMATCH at %0t: %s expected %0h got %0h", $time, what, want, got);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got)
			report_mismatch(name, want, got);
	endtask

	task automatic check_record(input result_t got);
		result_t want;
		if (expected_records.size() == 0) begin
			report_mismatch("record with none pending, kind", '0, 32'(got.record_kind));
			return;
		end
		want = expected_records.pop_front();
		compare_field("record_kind", want.record_kind, got.record_kind);
		compare_field("block_ok", want.block_ok, got.block_ok);
		compare_field("maker_letter_one", want.maker_letter_one, got.maker_letter_one);
		compare_field("maker_letter_two", want.maker_letter_two, got.maker_letter_two);
		compare_field("maker_letter_three", want.maker_letter_three, got.maker_letter_three);
		compare_field("numeric_serial", want.numeric_serial, got.numeric_serial);
		compare_field("numeric_serial_used", want.numeric_serial_used,
			got.numeric_serial_used);
		compare_field("char_index", want.char_index, got.char_index);
		compare_field("char_value", want.char_value, got.char_value);
		compare_field("text_length", want.text_length, got.text_length);
		compare_field("last_record", want.last_record, got.last_record);
	endtask

	always @(posedge clk)
		if (arst_n && strobe)
			check_record(result);

	// one item per call; sender idles in bursts
	task automatic send_item(input logic [7:0] b, input logic is_last);
		in_item <= '{edid_byte: b, last_byte: is_last};
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		absorb_edid_byte(b);
		if (is_last)
			emit_block_records();
		items_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 30);
			start <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
		end
	endtask

	task automatic send_block();
		for (int i = 0; i < block_len; i++)
			send_item(block_bytes[i], i == block_len - 1);
	endtask

	task automatic fill_block_base(input logic good_header, input logic [7:0] m0,
			input logic [7:0] m1, input logic [31:0] serial);
		for (int i = 0; i < MAX_BLOCK_LEN; i++)
			block_bytes[i] = 8'($urandom);
		block_bytes[OFF_HDR0] = HDR0_VAL;
		block_bytes[OFF_HDR1] = HDR1_VAL;
		if (!good_header) begin
			if ($urandom_range(0, 1))
				block_bytes[OFF_HDR0] = 8'($urandom_range(1, 255));
			else
				block_bytes[OFF_HDR1] = 8'($urandom_range(0, 254));
		end
		block_bytes[OFF_MAKER0] = m0;
		block_bytes[OFF_MAKER1] = m1;
		for (int i = 0; i < 4; i++)
			block_bytes[OFF_SERIAL + i] = serial[8*i +: 8];
		block_len = BLOCK_BYTES;
	endtask

	// text is 12 bytes, first character in the top byte
	task automatic put_descriptor(input int slot, input logic [7:0] f0, input logic [7:0] f2,
			input logic [7:0] tag, input logic [95:0] text);
		int base;
		base = DESC_FIRST + slot * (DESC_POS_LAST + 1);
		block_bytes[base + DESC_POS_FLAG0] = f0;
		block_bytes[base + DESC_POS_FLAG2] = f2;
		block_bytes[base + DESC_POS_TAG] = tag;
		for (int i = 0; i < TEXT_CHARS; i++)
			block_bytes[base + TEXT_POS_FIRST + i] = text[95 - 8*i -: 8];
	endtask

	function automatic logic [7:0] printable_char();
		return 8'($urandom_range(PRINT_LOW, PRINT_HIGH));
	endfunction

	// never a terminator
	function automatic logic [7:0] unprintable_char();
		int v;
		if ($urandom_range(0, 1))
			return 8'($urandom_range(8'h7f, 8'hff));
		v = $urandom_range(1, 31);
		if (v == CHAR_LF || v == CHAR_CR)
			v++;
		return 8'(v);
	endfunction

	function automatic logic [7:0] terminator_char();
		case ($urandom_range(0, 2))
			0: return CHAR_NUL;
			1: return CHAR_LF;
			default: return CHAR_CR;
		endcase
	endfunction

	function automatic logic [95:0] random_text();
		logic [95:0] t;
		int len;
		int bad;
		for (int i = 0; i < TEXT_CHARS; i++)
			t[95 - 8*i -: 8] = printable_char();
		case ($urandom_range(0, 3))
			0: t = {$urandom, $urandom, $urandom};
			1: begin
				len = $urandom_range(0, TEXT_CHARS);
				if (len < TEXT_CHARS)
					t[95 - 8*len -: 8] = terminator_char();
			end
			default: begin
				bad = $urandom_range(0, 7);
				for (int j = 0; j < bad; j++)
					t[95 - 8*$urandom_range(0, TEXT_CHARS - 1) -: 8] = unprintable_char();
				if ($urandom_range(0, 1))
					t[95 - 8*$urandom_range(0, TEXT_CHARS - 1) -: 8] = terminator_char();
			end
		endcase
		return t;
	endfunction

	task automatic random_descriptor(input int slot);
		logic [7:0] tag;
		logic [7:0] f0;
		logic [7:0] f2;
		if ($urandom_range(0, 9) < 2)
			return;
		case ($urandom_range(0, 7))
			0, 1, 2: tag = TAG_NAME;
			3, 4:    tag = TAG_SERIAL;
			5, 6:    tag = TAG_ALNUM;
			default: tag = 8'($urandom);
		endcase
		f0 = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
		f2 = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
		put_descriptor(slot, f0, f2, tag, random_text());
	endtask

	task automatic fill_random_block();
		logic [7:0] m0;
		logic [7:0] m1;
		logic [31:0] serial;
		case ($urandom_range(0, 3))
			0: begin m0 = 8'h00; m1 = 8'h00; end
			1: begin m0 = 8'hff; m1 = 8'hff; end
			default: begin m0 = 8'($urandom); m1 = 8'($urandom); end
		endcase
		case ($urandom_range(0, 3))
			0: serial = '0;
			1: serial = '1;
			default: serial = $urandom;
		endcase
		fill_block_base($urandom_range(0, 9) != 0, m0, m1, serial);
		for (int s = 0; s < 4; s++)
			random_descriptor(s);
	endtask

	task automatic test_short_runs();
		send_item(HDR0_VAL, 1'b1);
		send_item(8'hff, 1'b1);
		send_item(HDR0_VAL, 1'b0);
		send_item(HDR1_VAL, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(8'h00, 1'b1);
		for (int i = 0; i < 6; i++)
			send_item(8'($urandom), i == 5);
		fill_random_block();
		block_len = BLOCK_BYTES - 1;
		send_block();
	endtask

	task automatic test_string_cleaning();
		// edge printables kept, four bad chars kept, five bad chars blank,
		// a later empty name replaces the first one
		fill_block_base(1'b1, 8'hff, 8'hff, 32'hffff_ffff);
		put_descriptor(0, 8'h00, 8'h00, TAG_NAME, {8'h20, "BCDEFGHIJK", 8'h7e});
		put_descriptor(1, 8'h00, 8'h00, TAG_SERIAL,
			{8'h1f, 8'h7f, "A", 8'h80, 8'hff, "B", CHAR_LF, "Z1234"});
		put_descriptor(2, 8'h00, 8'h00, TAG_ALNUM,
			{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, CHAR_CR, "abcdef"});
		put_descriptor(3, 8'h00, 8'h00, TAG_NAME, {CHAR_NUL, "QRSTUVWXYZ!"});
		send_block();
		// ignored descriptors: flag bytes nonzero, unknown tag
		fill_block_base(1'b1, 8'h00, 8'h00, 32'h0);
		put_descriptor(0, 8'h01, 8'h00, TAG_NAME, "IGNOREDNAME1");
		put_descriptor(1, 8'h00, 8'hff, TAG_ALNUM, "IGNOREDALNUM");
		put_descriptor(2, 8'h00, 8'h00, 8'hfd, "UNKNOWNTAGXX");
		put_descriptor(3, 8'h00, 8'h00, TAG_NAME, {8'h7e, "0123456789", 8'h20});
		send_block();
	endtask

	task automatic test_bytes_past_block();
		fill_random_block();
		block_len = MAX_BLOCK_LEN;
		send_block();
	endtask

	task automatic test_random_blocks();
		int first_item;
		int first_record;
		first_item = items_sent;
		first_record = records_predicted;
		while (items_sent - first_item < 270 || records_predicted - first_record < 48) begin
			fill_random_block();
			case ($urandom_range(0, 19))
				0, 1:    block_len = $urandom_range(1, BLOCK_BYTES - 1);
				2, 3:    block_len = $urandom_range(BLOCK_BYTES + 1, BLOCK_BYTES + 12);
				4:       block_len = $urandom_range(256, MAX_BLOCK_LEN);
				default: block_len = BLOCK_BYTES;
			endcase
			send_block();
		end
	endtask

	initial begin
		repeat (CYCLE_LIMIT)
			@(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		in_item <= '0;
		clear_parse_state();
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_runs();
		test_string_cleaning();
		test_bytes_past_block();
		test_random_blocks();
		start <= 1'b0;
		while (expected_records.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* edid_base_block_parser_unit.f */
rtl/edid_pkg.sv
rtl/edid_ram.sv
rtl/edid_dp.sv
rtl/edid_ctrl.sv
rtl/edid_base_block_parser_unit.sv
bench/edid_base_block_parser_unit_test.sv
